// ----- design/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg - shared definitions for the base64 stream decoder
// Result kinds, character codes, the result record and the sextet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned MAX_RESULTS     = 3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_PAD = 8'h3D;

	localparam logic [6:0] NOT_SEXTET = 7'd64;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_count;
		logic        last;
	} result_t;

	// Up to three results produced by one character, entry 0 goes out first.
	typedef struct packed {
		logic [1:0]                      n;
		result_t [MAX_RESULTS-1:0]       ent;
	} bundle_t;

	// Maps a character of the standard alphabet to its 6-bit value.
	// Anything else returns NOT_SEXTET.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd64;
			if (c >= 8'h41 && c <= 8'h5A) begin
				v = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				v = c - 8'h47;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				v = c + 8'd4;
			end else if (c == 8'h2B) begin
				v = 8'd62;
			end else if (c == 8'h2F) begin
				v = 8'd63;
			end
			return v[6:0];
		end
	endfunction

endpackage

// ----- design/b64d_core.sv -----
// ----------------------------------------------------------------------------
// b64d_core - character register and group decode
// Registers one character, then updates the group state and builds the
// results for that character in a single pass.
// ----------------------------------------------------------------------------
module b64d_core #(
	parameter int unsigned COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	input  logic              room,
	output logic              load,
	output b64d_pkg::bundle_t bundle
);
	import b64d_pkg::*;

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   start_s1;

	logic [1:0]             pos_q;
	logic [23:0]            val_q;
	logic [2:0]             pad_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   stopped_q;

	logic [1:0]             pos_e, pos_n;
	logic [23:0]            val_e, val_n;
	logic [23:0]            grp;
	logic [2:0]             pad_e, pad_n, pad_inc;
	logic [COUNT_WIDTH-1:0] cnt_e, cnt_n;
	logic                   stopped_e, stopped_n;
	logic [COUNT_WIDTH-1:0] inc1, inc2, inc3;
	logic [6:0]             sx;
	logic                   is_pad, bad;
	logic [1:0]             nbytes;
	logic                   fire;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] c,
		input logic [1:0]             k
	);
		logic [COUNT_WIDTH+1:0] s;
		begin
			s = {2'b00, c} + (COUNT_WIDTH+2)'(k);
			if (s > {2'b00, {COUNT_WIDTH{1'b1}}}) begin
				return {COUNT_WIDTH{1'b1}};
			end
			return s[COUNT_WIDTH-1:0];
		end
	endfunction

	function automatic logic [15:0] count16(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_WIDTH+15:0] e;
		begin
			e = {16'd0, c};
			return e[15:0];
		end
	endfunction

	always_comb begin
		// A start request behaves as if the state had just been reset.
		pos_e     = start_s1 ? 2'd0 : pos_q;
		val_e     = start_s1 ? 24'd0 : val_q;
		pad_e     = start_s1 ? 3'd0 : pad_q;
		cnt_e     = start_s1 ? '0 : cnt_q;
		stopped_e = start_s1 ? 1'b0 : stopped_q;

		pos_n     = pos_e;
		val_n     = val_e;
		pad_n     = pad_e;
		cnt_n     = cnt_e;
		stopped_n = stopped_e;
		grp       = 24'd0;

		sx      = sextet_of(ch_s1);
		is_pad  = (ch_s1 == CH_PAD);
		bad     = (ch_s1 == CH_NUL) || ((sx == NOT_SEXTET) && !is_pad);
		pad_inc = pad_e + 3'd1;
		nbytes  = 2'd0;

		inc1 = sat_add(cnt_e, 2'd1);
		inc2 = sat_add(cnt_e, 2'd2);
		inc3 = sat_add(cnt_e, 2'd3);

		bundle.n = 2'd0;
		bundle.ent[0] = '{kind: KIND_ERR, data_byte: 8'd0,
			byte_count: count16(cnt_e), last: 1'b1};
		bundle.ent[1] = '0;
		bundle.ent[2] = '0;

		if (!stopped_e) begin
			if (bad) begin
				stopped_n = 1'b1;
				bundle.n  = 2'd1;
				bundle.ent[0].kind = (pos_e == 2'd0) ? KIND_DONE : KIND_ERR;
			end else if (is_pad && pad_inc > 3'd2) begin
				pad_n     = pad_inc;
				stopped_n = 1'b1;
				bundle.n  = 2'd1;
			end else if (!is_pad && pad_e != 3'd0) begin
				stopped_n = 1'b1;
				bundle.n  = 2'd1;
			end else begin
				grp   = {val_e[17:0], (is_pad ? 6'd0 : sx[5:0])};
				val_n = grp;
				pad_n = is_pad ? pad_inc : pad_e;
				if (pos_e != 2'd3) begin
					pos_n = pos_e + 2'd1;
				end else begin
					nbytes = 2'(3'd3 - pad_n);
					pos_n  = 2'd0;
					val_n  = 24'd0;
					pad_n  = 3'd0;
					case (nbytes)
						2'd1: cnt_n = inc1;
						2'd2: cnt_n = inc2;
						default: cnt_n = inc3;
					endcase
					bundle.n = nbytes;
					bundle.ent[0] = '{kind: KIND_DATA, data_byte: grp[23:16],
						byte_count: count16(inc1), last: (nbytes == 2'd1)};
					bundle.ent[1] = '{kind: KIND_DATA, data_byte: grp[15:8],
						byte_count: count16(inc2), last: (nbytes == 2'd2)};
					bundle.ent[2] = '{kind: KIND_DATA, data_byte: grp[7:0],
						byte_count: count16(inc3), last: 1'b1};
				end
			end
		end

		fire     = valid_s1 && ((bundle.n == 2'd0) || room);
		load     = fire && (bundle.n != 2'd0);
		s_tready = !valid_s1 || fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			val_q     <= 24'd0;
			pad_q     <= 3'd0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			pos_q     <= pos_n;
			val_q     <= val_n;
			pad_q     <= pad_n;
			cnt_q     <= cnt_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

// ----- design/b64d_out.sv -----
// ----------------------------------------------------------------------------
// b64d_out - result register and serializer
// Holds the results of one character and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module b64d_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64d_pkg::bundle_t bundle,
	output logic              room,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // data_byte [7:0], byte_count [23:8]
	output logic [1:0]        m_tuser,  // kind [1:0]
	output logic              m_tlast
);
	import b64d_pkg::*;

	result_t    ent_q [MAX_RESULTS];
	logic [1:0] cnt_q;
	logic       take;

	assign room     = (cnt_q == 2'd0);
	assign m_tvalid = (cnt_q != 2'd0);
	assign take     = m_tvalid && m_tready;
	assign m_tdata  = {ent_q[0].byte_count, ent_q[0].data_byte};
	assign m_tuser  = ent_q[0].kind;
	assign m_tlast  = ent_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// A new set is loaded only when the register is empty.
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q[0] <= bundle.ent[0];
			ent_q[1] <= bundle.ent[1];
			ent_q[2] <= bundle.ent[2];
		end else if (take) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule

// ----- design/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder - streaming base64 decoder, standard alphabet
// Decodes one text character per beat into data, finish and error results.
//
//   channel  dir  tdata                         tuser        tlast
//   s_*      in   ch [7:0]                      start_req    -
//   m_*      out  data_byte [7:0],              kind [1:0]   last
//                 byte_count [23:8]
//
// A character is registered and then decoded; one character is taken every
// cycle unless one with results waits. A completed group loads up to three
// results into the output register, which sends one beat per cycle while
// m_tready is high; the group's next characters go on meanwhile. A character
// with results waits only while the output register still holds results of
// an earlier character. Reset clears the decoder state.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
	parameter int unsigned COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch [7:0]
	input  logic        s_tuser,   // start_req [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // data_byte [7:0], byte_count [23:8]
	output logic [1:0]  m_tuser,   // kind [1:0]
	output logic        m_tlast
);
	import b64d_pkg::*;

	bundle_t bundle;
	logic    load;
	logic    room;

	b64d_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.room    (room),
		.load    (load),
		.bundle  (bundle)
	);

	b64d_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.bundle  (bundle),
		.room    (room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
